// ----- src/rgb_to_hsv_core_macros.svh -----
// assertion macros for the rgb to hsv converter
`ifndef RGB_TO_HSV_CORE_MACROS_SVH
`define RGB_TO_HSV_CORE_MACROS_SVH

`ifndef SYNTH
// same-cycle implication, sampled on clk_i, off while in reset
`define R2H_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("r2h check failed");
// next-cycle implication, sampled on clk_i, off while in reset
`define R2H_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("r2h check failed");
`else
`define R2H_ASSERT_IMP(label, ante, cons)
`define R2H_ASSERT_NXT(label, ante, cons)
`endif

`endif

// ----- src/r2h_pkg.sv -----
// shared widths and the per-stage payload type of the rgb to hsv converter
`timescale 1ns / 1ps

package r2h_pkg;

  localparam int unsigned ChanW    = 8;   // one color channel
  localparam int unsigned HueW     = 16;  // hue, one quotient bit per cell
  localparam int unsigned HueRemW  = 11;  // holds 6 * range, up to 1530
  localparam int unsigned SatNumW  = 2 * ChanW;
  localparam int unsigned CellCount = HueW;

  // payload handed from one stage to the next
  typedef struct packed {
    logic [HueRemW-1:0] hue_rem;
    logic [HueRemW-1:0] hue_div;
    logic [HueW-1:0]    hue_q;
    logic [ChanW-1:0]   sat_rem;
    logic [ChanW-1:0]   sat_div;
    logic [SatNumW-1:0] sat_num;
    logic [ChanW-1:0]   sat_q;
    logic [ChanW-1:0]   bright;
    logic               hue_zero;
    logic               sat_zero;
  } lane_t;

endpackage

// ----- src/rgb_to_hsv_core.sv -----
// rgb to hsv pixel converter, top level
`timescale 1ns / 1ps

// Converts one 8-bit RGB pixel per request into hue (16 bits, fraction of a
// full turn), saturation (8 bits, 255 = 1.0, truncated) and value (largest
// channel). Throughput is one pixel every clock cycle while the pipeline
// is not stalled. The accepting edge loads the front stage (max, min,
// range, hue sector setup). The pixel then passes a row of 16 division
// cells, each producing one hue quotient bit and one saturation quotient
// bit. The output register comes last.
// The 16-cell row, one quotient bit per cell, sets the latency. The whole
// pipeline advances together; it stalls only while a finished pixel sits in
// the output register and the sink is not ready. Black pixels give zero hue
// and saturation, grey pixels give zero hue. Ties for the maximum resolve
// red first, then green. No state is kept between pixels.

`include "rgb_to_hsv_core_macros.svh"

module rgb_to_hsv_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input pixel stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // red [7:0], green [15:8], blue [23:16]
  // output hsv stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // hue [15:0], saturation [23:16], brightness [31:24]
);

  // global advance: move whenever the output register is free or being drained
  logic en;

  logic           front_valid;
  r2h_pkg::lane_t front_lane;

  logic           cell_valid [r2h_pkg::CellCount];
  r2h_pkg::lane_t cell_lane  [r2h_pkg::CellCount];

  logic           out_valid_q;
  logic [31:0]    out_data_d, out_data_q;
  r2h_pkg::lane_t last_lane;

  assign en            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;

  // setup stage
  r2h_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .red_i   (s_axis_tdata[7:0]),
    .green_i (s_axis_tdata[15:8]),
    .blue_i  (s_axis_tdata[23:16]),
    .valid_o (front_valid),
    .lane_o  (front_lane)
  );

  // division cells, each hands its partial results to the next
  for (genvar i = 0; i < r2h_pkg::CellCount; i++) begin : g_cell
    if (i == 0) begin : g_first
      r2h_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .en_i    (en),
        .valid_i (front_valid),
        .lane_i  (front_lane),
        .valid_o (cell_valid[i]),
        .lane_o  (cell_lane[i])
      );
    end else begin : g_next
      r2h_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .en_i    (en),
        .valid_i (cell_valid[i-1]),
        .lane_i  (cell_lane[i-1]),
        .valid_o (cell_valid[i]),
        .lane_o  (cell_lane[i])
      );
    end
  end

  // zero forcing for grey and black pixels, where the divisor was zero
  always_comb begin
    last_lane  = cell_lane[r2h_pkg::CellCount-1];
    out_data_d = {last_lane.bright,
                  last_lane.sat_zero ? 8'h00 : last_lane.sat_q,
                  last_lane.hue_zero ? 16'h0000 : last_lane.hue_q};
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= cell_valid[r2h_pkg::CellCount-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // a black pixel never leaves with a hue or a saturation
  `R2H_ASSERT_IMP(a_black_zero, m_axis_tvalid && ~|m_axis_tdata[31:24], ~|m_axis_tdata[23:0])
  // an accepted request lands in the front stage
  `R2H_ASSERT_NXT(a_accept_front, s_axis_tvalid && s_axis_tready, front_valid)
  // the last cell's pixel reaches the output register when the pipe moves
  `R2H_ASSERT_NXT(a_last_to_out, cell_valid[r2h_pkg::CellCount-1] && en, m_axis_tvalid)

endmodule

// ----- src/r2h_front.sv -----
// front stage: max, min, range, hue sector and the two division setups
`timescale 1ns / 1ps

module r2h_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            valid_i,
  input  logic [r2h_pkg::ChanW-1:0]       red_i,
  input  logic [r2h_pkg::ChanW-1:0]       green_i,
  input  logic [r2h_pkg::ChanW-1:0]       blue_i,
  output logic                            valid_o,
  output r2h_pkg::lane_t                  lane_o
);

  logic [7:0]         hi_rg, lo_rg, hi, lo, range;
  logic signed [11:0] num_raw, num_wrap;
  logic [10:0]        div6;
  logic               valid_q;
  r2h_pkg::lane_t     lane_d, lane_q;

  always_comb begin
    hi_rg = (red_i > green_i) ? red_i : green_i;
    hi    = (hi_rg > blue_i) ? hi_rg : blue_i;
    lo_rg = (red_i < green_i) ? red_i : green_i;
    lo    = (lo_rg < blue_i) ? lo_rg : blue_i;
    range = hi - lo;
    div6  = {1'b0, range, 2'b00} + {2'b00, range, 1'b0};

    // sector order: red, then green, then blue
    if (red_i == hi) begin
      num_raw = $signed({4'b0000, green_i}) - $signed({4'b0000, blue_i});
    end else if (green_i == hi) begin
      num_raw = $signed({3'b000, range, 1'b0}) + $signed({4'b0000, blue_i})
              - $signed({4'b0000, red_i});
    end else begin
      num_raw = $signed({2'b00, range, 2'b00}) + $signed({4'b0000, red_i})
              - $signed({4'b0000, green_i});
    end
    num_wrap = (num_raw < 0) ? (num_raw + $signed({1'b0, div6})) : num_raw;

    lane_d          = '0;
    lane_d.hue_rem  = num_wrap[10:0];
    lane_d.hue_div  = div6;
    lane_d.sat_div  = hi;
    lane_d.sat_num  = {range, 8'h00} - {8'h00, range};  // range * 255
    lane_d.bright   = hi;
    lane_d.hue_zero = (range == 8'h00);
    lane_d.sat_zero = (hi == 8'h00);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_q <= lane_d;
    end
  end

  assign valid_o = valid_q;
  assign lane_o  = lane_q;

endmodule

// ----- src/r2h_cell.sv -----
// one division cell: one hue quotient bit and one saturation quotient bit
`timescale 1ns / 1ps

module r2h_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  r2h_pkg::lane_t lane_i,
  output logic           valid_o,
  output r2h_pkg::lane_t lane_o
);

  logic [11:0]    hue_t, hue_sub;
  logic           hue_ge;
  logic [8:0]     sat_t, sat_sub;
  logic           sat_ge;
  logic           valid_q;
  r2h_pkg::lane_t lane_d, lane_q;

  always_comb begin
    // hue: fractional restoring step, remainder stays below the divisor
    hue_t   = {lane_i.hue_rem, 1'b0};
    hue_sub = hue_t - {1'b0, lane_i.hue_div};
    hue_ge  = (hue_t >= {1'b0, lane_i.hue_div});
    // saturation: long division, dividend bits enter from the top
    sat_t   = {lane_i.sat_rem, lane_i.sat_num[r2h_pkg::SatNumW-1]};
    sat_sub = sat_t - {1'b0, lane_i.sat_div};
    sat_ge  = (sat_t >= {1'b0, lane_i.sat_div});

    lane_d         = lane_i;
    lane_d.hue_rem = hue_ge ? hue_sub[10:0] : hue_t[10:0];
    lane_d.hue_q   = {lane_i.hue_q[r2h_pkg::HueW-2:0], hue_ge};
    lane_d.sat_rem = sat_ge ? sat_sub[7:0] : sat_t[7:0];
    lane_d.sat_num = {lane_i.sat_num[r2h_pkg::SatNumW-2:0], 1'b0};
    lane_d.sat_q   = {lane_i.sat_q[r2h_pkg::ChanW-2:0], sat_ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_q <= lane_d;
    end
  end

  assign valid_o = valid_q;
  assign lane_o  = lane_q;

endmodule
